// ----- hw/rtl/dhsf_pkg.sv -----
// Shared types and constants of the DLE handshake shortcut filter.
package dhsf_pkg;

  // Input item kinds
  typedef enum logic [1:0] {
    KIND_BYTE       = 2'd0,
    KIND_CONNECT    = 2'd1,
    KIND_DISCONNECT = 2'd2,
    KIND_TICK       = 2'd3
  } kind_t;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_ENABLED = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT = 2'd1;
  localparam logic [7:0] TIMEOUT_RESET = 8'd30;

  // Handshake phases
  localparam logic [2:0] PH_OFF         = 3'd0;
  localparam logic [2:0] PH_MASTER_S    = 3'd1;
  localparam logic [2:0] PH_MASTER_U    = 3'd2;
  localparam logic [2:0] PH_SLAVE_SHERE = 3'd3;
  localparam logic [2:0] PH_SLAVE_RP    = 3'd4;
  localparam logic [2:0] PH_DONE        = 3'd5;

  // Peer roles
  localparam logic [1:0] ROLE_NONE   = 2'd0;
  localparam logic [1:0] ROLE_MASTER = 2'd1;
  localparam logic [1:0] ROLE_SLAVE  = 2'd2;

  // Canned command codes
  localparam logic [2:0] INJ_NONE     = 3'd0;
  localparam logic [2:0] INJ_SHERE    = 3'd1;
  localparam logic [2:0] INJ_ROK      = 3'd2;
  localparam logic [2:0] INJ_PY       = 3'd3;
  localparam logic [2:0] INJ_S_INTRO  = 3'd4;
  localparam logic [2:0] INJ_UY       = 3'd5;

  // Receive hold controls
  localparam logic [1:0] HOLD_NONE    = 2'd0;
  localparam logic [1:0] HOLD_ARM     = 2'd1;
  localparam logic [1:0] HOLD_FLUSH   = 2'd2;
  localparam logic [1:0] HOLD_DISCARD = 2'd3;

  // Characters
  localparam logic [7:0] DLE_CODE = 8'h10;
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_S     = 8'h53;
  localparam logic [7:0] CH_U     = 8'h55;
  localparam logic [7:0] CH_R     = 8'h52;
  localparam logic [7:0] CH_P     = 8'h50;
  localparam int unsigned SHERE_LEN = 5;

  // Result queue depth
  localparam int unsigned OUTQ_DEPTH = 4;
  localparam int unsigned OUTQ_AW    = 2;

  // Session state, apart from the command length
  typedef struct packed {
    logic [2:0] phase;
    logic [1:0] role;
    logic       in_command;
    logic [7:0] first_char;
    logic       prefix_match;
    logic       seen_r;
    logic       seen_p;
    logic       peer_name_known;
    logic [7:0] elapsed_ticks;
    logic       timer_running;
  } sess_t;

  localparam sess_t SESS_RESET = '0;

  // One result beat
  typedef struct packed {
    logic       pass_valid;
    logic [7:0] pass_byte;
    logic [2:0] inject_code;
    logic [1:0] hold_control;
    logic [2:0] phase_now;
    logic       last;
  } res_t;

  // Results pushed by the core for one accepted item
  typedef struct packed {
    logic valid;
    logic two;
    res_t r0;
    res_t r1;
  } push_t;

  // Character of "Shere" at a given position
  function automatic logic [7:0] shere_char(input logic [2:0] idx);
    logic [7:0] c;
    case (idx)
      3'd0:    c = 8'h53;
      3'd1:    c = 8'h68;
      3'd2:    c = 8'h65;
      3'd3:    c = 8'h72;
      3'd4:    c = 8'h65;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

// ----- hw/rtl/dle_handshake_shortcut_filter_unit.sv -----
// Top level of the DLE handshake shortcut filter.
//
// Input channel (in_valid/in_ready): one beat per event: an outgoing byte,
// a connect, a disconnect or a one-second tick. Every beat yields one result
// beat, or two when a master frames the remote S command (ROK, then Py).
// Output channel (out_valid/out_ready): result beats in order; last marks
// the final beat of an input. Config channel (cfg_valid/cfg_ready) writes
// register 0 (enabled) or 1 (timeout_seconds); it is always ready.
// A result beat is offered the cycle after its input is accepted if no older
// beats wait. Throughput: one input beat per cycle while results drain at the
// same rate; the session state update happens in the accept cycle, so the
// next byte sees it at once. A 4-entry result queue sets the backpressure:
// in_ready is high while the queue has room for two beats, so a stalled
// receiver stops input after two or three beats and nothing is lost.
// Reset: disabled, timeout 30, phase off, queue empty.
module dle_handshake_shortcut_filter_unit #(
  parameter int unsigned CMD_MAX = 256
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [1:0]                     kind,
  input  logic [7:0]                     data_byte,
  input  logic                           outgoing,
  input  logic                           login_prompt,
  input  logic                           peer_known,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           pass_valid,
  output logic [7:0]                     pass_byte,
  output logic [2:0]                     inject_code,
  output logic [1:0]                     hold_control,
  output logic [2:0]                     phase_now,
  output logic                           last,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [dhsf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]                     cfg_data
);

  dhsf_pkg::push_t push;
  dhsf_pkg::res_t  head;
  logic            in_accept;
  logic            space_ok;

  assign in_ready  = space_ok;
  assign in_accept = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  // Session logic
  dhsf_core #(
    .CMD_MAX(CMD_MAX)
  ) u_core (
    .clk         (clk),
    .rst         (rst),
    .in_accept   (in_accept),
    .kind        (kind),
    .data_byte   (data_byte),
    .outgoing    (outgoing),
    .login_prompt(login_prompt),
    .peer_known  (peer_known),
    .cfg_we      (cfg_valid && cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .push        (push)
  );

  // Result queue
  dhsf_outq u_outq (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .space_ok (space_ok),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .head     (head)
  );

  assign pass_valid   = head.pass_valid;
  assign pass_byte    = head.pass_byte;
  assign inject_code  = head.inject_code;
  assign hold_control = head.hold_control;
  assign phase_now    = head.phase_now;
  assign last         = head.last;

endmodule

// ----- hw/rtl/dhsf_core.sv -----
// Session state, command framing and result generation for one item per cycle.
module dhsf_core #(
  parameter int unsigned CMD_MAX = 256
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_accept,
  input  logic [1:0]                        kind,
  input  logic [7:0]                        data_byte,
  input  logic                              outgoing,
  input  logic                              login_prompt,
  input  logic                              peer_known,
  input  logic                              cfg_we,
  input  logic [dhsf_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [7:0]                        cfg_data,
  output dhsf_pkg::push_t                   push
);

  localparam int unsigned LEN_W = $clog2(CMD_MAX);
  localparam logic [LEN_W:0] CMD_LIMIT = (LEN_W + 1)'(CMD_MAX);

  dhsf_pkg::sess_t sess;
  dhsf_pkg::sess_t sess_next;
  logic [LEN_W-1:0] command_length;
  logic [LEN_W-1:0] command_length_next;
  logic             enabled;
  logic [7:0]       timeout_seconds;

  logic [LEN_W:0]   len_inc;
  logic             active;
  logic             is_term;
  logic             keep_phase0;
  logic             seen_r_n;
  logic             seen_p_n;
  dhsf_pkg::res_t   r0;
  dhsf_pkg::res_t   r1;
  logic             two;

  assign len_inc = {1'b0, command_length} + (LEN_W + 1)'(1);
  assign active  = (sess.phase == dhsf_pkg::PH_MASTER_S) ||
                   (sess.phase == dhsf_pkg::PH_MASTER_U) ||
                   (sess.phase == dhsf_pkg::PH_SLAVE_SHERE) ||
                   (sess.phase == dhsf_pkg::PH_SLAVE_RP);
  assign is_term = (data_byte == dhsf_pkg::CH_NUL) || (data_byte == dhsf_pkg::CH_CR) ||
                   (data_byte == dhsf_pkg::CH_LF);
  assign seen_r_n = sess.seen_r | (sess.first_char == dhsf_pkg::CH_R);
  assign seen_p_n = sess.seen_p | (sess.first_char == dhsf_pkg::CH_P);

  // Compute next session state and the results of the item
  always_comb begin
    sess_next           = sess;
    command_length_next = command_length;
    r0                  = '0;
    r0.last             = 1'b1;
    r1                  = '0;
    r1.last             = 1'b1;
    two                 = 1'b0;
    keep_phase0         = 1'b0;
    case (dhsf_pkg::kind_t'(kind))
      dhsf_pkg::KIND_BYTE: begin
        if (!enabled || !active) begin
          r0.pass_valid = 1'b1;
          r0.pass_byte  = data_byte;
        end else if (sess.timer_running && (sess.elapsed_ticks > timeout_seconds)) begin
          // timeout: flush the hold and fall back to pass-through
          sess_next           = dhsf_pkg::SESS_RESET;
          command_length_next = '0;
          r0.pass_valid       = 1'b1;
          r0.pass_byte        = data_byte;
          r0.hold_control     = dhsf_pkg::HOLD_FLUSH;
        end else if (!sess.in_command) begin
          if (data_byte == dhsf_pkg::DLE_CODE) begin
            sess_next.in_command   = 1'b1;
            sess_next.first_char   = '0;
            sess_next.prefix_match = 1'b1;
            command_length_next    = '0;
          end
        end else if (is_term) begin
          // command framed: match against the canned exchange
          sess_next.in_command = 1'b0;
          if (sess.role == dhsf_pkg::ROLE_MASTER) begin
            if (sess.phase == dhsf_pkg::PH_MASTER_S && sess.first_char == dhsf_pkg::CH_S) begin
              sess_next.phase = dhsf_pkg::PH_MASTER_U;
              r0.inject_code  = dhsf_pkg::INJ_ROK;
              r0.last         = 1'b0;
              r1.inject_code  = dhsf_pkg::INJ_PY;
              keep_phase0     = 1'b1;
              two             = 1'b1;
            end else if (sess.phase == dhsf_pkg::PH_MASTER_U &&
                         sess.first_char == dhsf_pkg::CH_U) begin
              sess_next.phase = dhsf_pkg::PH_DONE;
              r0.hold_control = dhsf_pkg::HOLD_FLUSH;
            end
          end else if (sess.role == dhsf_pkg::ROLE_SLAVE) begin
            if (sess.phase == dhsf_pkg::PH_SLAVE_SHERE && sess.prefix_match &&
                command_length >= LEN_W'(dhsf_pkg::SHERE_LEN)) begin
              if (!sess.peer_name_known) begin
                sess_next           = dhsf_pkg::SESS_RESET;
                command_length_next = '0;
                r0.hold_control     = dhsf_pkg::HOLD_DISCARD;
              end else begin
                sess_next.phase = dhsf_pkg::PH_SLAVE_RP;
                r0.inject_code  = dhsf_pkg::INJ_S_INTRO;
              end
            end else if (sess.phase == dhsf_pkg::PH_SLAVE_RP) begin
              sess_next.seen_r = seen_r_n;
              sess_next.seen_p = seen_p_n;
              if (seen_r_n && seen_p_n) begin
                sess_next.phase = dhsf_pkg::PH_DONE;
                r0.inject_code  = dhsf_pkg::INJ_UY;
                r0.hold_control = dhsf_pkg::HOLD_FLUSH;
              end
            end
          end
        end else if (len_inc < CMD_LIMIT) begin
          // payload byte: track first char and the Shere prefix
          if (command_length == '0) begin
            sess_next.first_char = data_byte;
          end
          if ((command_length < LEN_W'(dhsf_pkg::SHERE_LEN)) &&
              (data_byte != dhsf_pkg::shere_char(command_length[2:0]))) begin
            sess_next.prefix_match = 1'b0;
          end
          command_length_next = len_inc[LEN_W-1:0];
        end else begin
          // command overflow: drop the session
          sess_next           = dhsf_pkg::SESS_RESET;
          command_length_next = '0;
          r0.pass_valid       = 1'b1;
          r0.pass_byte        = data_byte;
          r0.hold_control     = dhsf_pkg::HOLD_DISCARD;
        end
      end
      dhsf_pkg::KIND_CONNECT: begin
        if (enabled) begin
          sess_next           = dhsf_pkg::SESS_RESET;
          command_length_next = '0;
          if ((!outgoing && login_prompt) || (outgoing && !peer_known)) begin
            r0.hold_control = dhsf_pkg::HOLD_DISCARD;
          end else begin
            sess_next.role            = outgoing ? dhsf_pkg::ROLE_MASTER : dhsf_pkg::ROLE_SLAVE;
            sess_next.phase           = outgoing ? dhsf_pkg::PH_MASTER_S :
                                                   dhsf_pkg::PH_SLAVE_SHERE;
            sess_next.peer_name_known = peer_known;
            sess_next.timer_running   = 1'b1;
            r0.inject_code            = outgoing ? dhsf_pkg::INJ_SHERE : dhsf_pkg::INJ_NONE;
            r0.hold_control           = dhsf_pkg::HOLD_ARM;
          end
        end
      end
      dhsf_pkg::KIND_DISCONNECT: begin
        sess_next           = dhsf_pkg::SESS_RESET;
        command_length_next = '0;
        r0.hold_control     = dhsf_pkg::HOLD_DISCARD;
      end
      dhsf_pkg::KIND_TICK: begin
        // saturating tick count while the timer runs
        if (sess.timer_running && (sess.elapsed_ticks != 8'hFF)) begin
          sess_next.elapsed_ticks = sess.elapsed_ticks + 8'd1;
        end
      end
      default: begin
      end
    endcase
    r0.phase_now = keep_phase0 ? sess.phase : sess_next.phase;
    r1.phase_now = sess_next.phase;
  end

  assign push.valid = in_accept;
  assign push.two   = two;
  assign push.r0    = r0;
  assign push.r1    = r1;

  // Hold configuration and session state
  always_ff @(posedge clk) begin
    if (rst) begin
      sess            <= dhsf_pkg::SESS_RESET;
      command_length  <= '0;
      enabled         <= 1'b0;
      timeout_seconds <= dhsf_pkg::TIMEOUT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        dhsf_pkg::REG_ENABLED: begin
          enabled <= cfg_data[0];
          if (!cfg_data[0]) begin
            sess           <= dhsf_pkg::SESS_RESET;
            command_length <= '0;
          end
        end
        dhsf_pkg::REG_TIMEOUT: timeout_seconds <= cfg_data;
        default: begin
        end
      endcase
    end else if (in_accept) begin
      sess           <= sess_next;
      command_length <= command_length_next;
    end
  end

endmodule

// ----- hw/rtl/dhsf_outq.sv -----
// Result queue: takes one or two result beats per cycle, delivers one while out_ready is high.
module dhsf_outq (
  input  logic            clk,
  input  logic            rst,
  input  dhsf_pkg::push_t push,
  output logic            space_ok,
  output logic            out_valid,
  input  logic            out_ready,
  output dhsf_pkg::res_t  head
);

  localparam int unsigned CNT_W = dhsf_pkg::OUTQ_AW + 1;

  dhsf_pkg::res_t mem [dhsf_pkg::OUTQ_DEPTH];
  logic [dhsf_pkg::OUTQ_AW-1:0] wr_ptr;
  logic [dhsf_pkg::OUTQ_AW-1:0] rd_ptr;
  logic [CNT_W-1:0]             count;
  logic [CNT_W-1:0]             push_n;
  logic                         pop;

  assign out_valid = (count != '0);
  assign head      = mem[rd_ptr];
  assign pop       = out_valid && out_ready;
  assign space_ok  = (count <= CNT_W'(dhsf_pkg::OUTQ_DEPTH - 2));
  assign push_n    = !push.valid ? CNT_W'(0) : (push.two ? CNT_W'(2) : CNT_W'(1));

  // Store pushed beats
  always_ff @(posedge clk) begin
    if (push.valid) begin
      mem[wr_ptr] <= push.r0;
      if (push.two) begin
        mem[wr_ptr + dhsf_pkg::OUTQ_AW'(1)] <= push.r1;
      end
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + push_n[dhsf_pkg::OUTQ_AW-1:0];
      if (pop) begin
        rd_ptr <= rd_ptr + dhsf_pkg::OUTQ_AW'(1);
      end
      count <= count + push_n - CNT_W'(pop);
    end
  end

endmodule
